/* hdl/dltq_pkg.sv */
// shared types and constants for the delta list timer queue
// no dependencies; imported by dltq_cell and delta_list_timer_queue
package dltq_pkg;

    localparam int DEF_TIMER_SLOTS = 16;
    localparam int DEF_DELTA_BITS  = 32;

    localparam int TIMEOUT_BITS  = 32;
    localparam int TAG_BITS      = 16;
    localparam int SLOT_OUT_BITS = 4;
    localparam int TICK_BITS     = 32;
    localparam int KIND_BITS     = 3;
    localparam int ACTION_BITS   = 2;
    localparam int S_DATA_BITS   = 56;
    localparam int M_DATA_BITS   = 56;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_CREATE = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_CREATED    = 3'd0,
        KIND_CREATE_REJ = 3'd1,
        KIND_DELETED    = 3'd2,
        KIND_DELETE_REJ = 3'd3,
        KIND_FIRED      = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        TOK_NONE,
        TOK_INS,
        TOK_CARRY,
        TOK_DEL,
        TOK_PULL,
        TOK_PASS
    } t_tok_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_DEC,
        ST_FIRE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic shift_left;
        logic dec;
    } t_cell_cmd;

endpackage

/* hdl/delta_list_timer_queue.sv */
// delta list timer queue: control, slot pool and a row of list cells
// depends on dltq_pkg and dltq_cell
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser action, tdata timeout/tag/slot
// m_axis    out  m_axis_tvalid / m_axis_tready   tuser kind, tdata slot/tag/ticks, tlast
//
// one item at a time; a token walks one cell per cycle
// create: accept, scan for a free slot, walk the token along the row, emit
// delete: accept, walk, emit; zero timeout and delete rejects go straight to emit; full pool scans, then emits
// tick: returns to idle on an empty list, else decrements the head, then fires each expired timer
// a stalled output holds the block until the output register frees
// reset is synchronous active low and empties the list at once
module delta_list_timer_queue #(
    parameter int TIMER_SLOTS = dltq_pkg::DEF_TIMER_SLOTS,
    parameter int DELTA_BITS  = dltq_pkg::DEF_DELTA_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // timeout [31:0], callback_tag [47:32], timer_slot [51:48]
    input  logic [dltq_pkg::S_DATA_BITS-1:0] s_axis_tdata,
    // action [1:0]
    input  logic [dltq_pkg::ACTION_BITS-1:0] s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // slot [3:0], fired_tag [19:4], tick_count [51:20]
    output logic [dltq_pkg::M_DATA_BITS-1:0] m_axis_tdata,
    // kind [2:0]
    output logic [dltq_pkg::KIND_BITS-1:0]   m_axis_tuser,
    output logic                             m_axis_tlast
);
    import dltq_pkg::*;

    localparam int SLOT_BITS = $clog2(TIMER_SLOTS);
    localparam int CMP_BITS  = (SLOT_BITS > SLOT_OUT_BITS) ? SLOT_BITS : SLOT_OUT_BITS;
    localparam int M_PAD     = M_DATA_BITS - TICK_BITS - TAG_BITS - SLOT_OUT_BITS;

    function automatic logic [SLOT_OUT_BITS-1:0] f_slot_out(input logic [SLOT_BITS-1:0] s);
        logic [CMP_BITS-1:0] ext;
        ext = CMP_BITS'(s);
        return ext[SLOT_OUT_BITS-1:0];
    endfunction

    // input unpacking
    t_action                  w_in_action;
    logic [TIMEOUT_BITS-1:0]  w_in_timeout;
    logic [TAG_BITS-1:0]      w_in_tag;
    logic [SLOT_OUT_BITS-1:0] w_in_slot;
    logic [DELTA_BITS-1:0]    w_in_rem;
    logic [CMP_BITS-1:0]      w_del_ext;
    logic                     w_del_range;
    logic [SLOT_BITS-1:0]     w_del_idx;

    assign w_in_action  = t_action'(s_axis_tuser);
    assign w_in_timeout = s_axis_tdata[TIMEOUT_BITS-1:0];
    assign w_in_tag     = s_axis_tdata[TIMEOUT_BITS +: TAG_BITS];
    assign w_in_slot    = s_axis_tdata[TIMEOUT_BITS+TAG_BITS +: SLOT_OUT_BITS];
    assign w_del_ext    = CMP_BITS'(w_in_slot);
    assign w_del_range  = ({1'b0, w_del_ext} < (CMP_BITS+1)'(TIMER_SLOTS));
    assign w_del_idx    = w_del_ext[SLOT_BITS-1:0];

    if (DELTA_BITS >= TIMEOUT_BITS) begin : g_rem_wide
        assign w_in_rem = DELTA_BITS'(w_in_timeout);
    end else begin : g_rem_sat
        assign w_in_rem = (|w_in_timeout[TIMEOUT_BITS-1:DELTA_BITS]) ? '1
                        : w_in_timeout[DELTA_BITS-1:0];
    end

    // registers
    t_state                   r_state, n_state;
    logic [TIMER_SLOTS-1:0]   r_busy, n_busy;
    logic [SLOT_BITS-1:0]     r_scan, n_scan;
    logic [DELTA_BITS-1:0]    r_rem, n_rem;
    logic [TICK_BITS-1:0]     r_tick, n_tick;
    t_tok_mode                r_inj_mode, n_inj_mode;
    logic [DELTA_BITS-1:0]    r_inj_delta, n_inj_delta;
    logic [SLOT_BITS-1:0]     r_inj_slot, n_inj_slot;
    logic [TAG_BITS-1:0]      r_inj_tag, n_inj_tag;
    t_kind                    r_res_kind, n_res_kind;
    logic [SLOT_OUT_BITS-1:0] r_res_slot, n_res_slot;
    logic [TAG_BITS-1:0]      r_res_tag, n_res_tag;
    logic                     r_out_valid, n_out_valid;
    t_kind                    r_out_kind, n_out_kind;
    logic [SLOT_OUT_BITS-1:0] r_out_slot, n_out_slot;
    logic [TAG_BITS-1:0]      r_out_tag, n_out_tag;
    logic [TICK_BITS-1:0]     r_out_tick, n_out_tick;
    logic                     r_out_last, n_out_last;

    t_cell_cmd                c_cmd;

    // cell row, index TIMER_SLOTS is the empty end of the row
    logic [TIMER_SLOTS:0]     w_valid;
    logic [SLOT_BITS-1:0]     w_slot      [TIMER_SLOTS+1];
    logic [DELTA_BITS-1:0]    w_delta     [TIMER_SLOTS+1];
    logic [TAG_BITS-1:0]      w_tag       [TIMER_SLOTS+1];
    t_tok_mode                w_tok_mode  [TIMER_SLOTS+1];
    logic [DELTA_BITS-1:0]    w_tok_delta [TIMER_SLOTS+1];
    logic [SLOT_BITS-1:0]     w_tok_slot  [TIMER_SLOTS+1];
    logic [TAG_BITS-1:0]      w_tok_tag   [TIMER_SLOTS+1];

    assign w_valid[TIMER_SLOTS] = 1'b0;
    assign w_slot[TIMER_SLOTS]  = '0;
    assign w_delta[TIMER_SLOTS] = '0;
    assign w_tag[TIMER_SLOTS]   = '0;
    assign w_tok_mode[0]        = r_inj_mode;
    assign w_tok_delta[0]       = r_inj_delta;
    assign w_tok_slot[0]        = r_inj_slot;
    assign w_tok_tag[0]         = r_inj_tag;

    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        t_cell_cmd w_cell_cmd;
        assign w_cell_cmd.shift_left = c_cmd.shift_left;
        assign w_cell_cmd.dec        = c_cmd.dec && (i == 0);

        dltq_cell #(
            .DELTA_BITS (DELTA_BITS),
            .SLOT_BITS  (SLOT_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cell_cmd),
            .i_tok_mode  (w_tok_mode[i]),
            .i_tok_delta (w_tok_delta[i]),
            .i_tok_slot  (w_tok_slot[i]),
            .i_tok_tag   (w_tok_tag[i]),
            .i_nbr_valid (w_valid[i+1]),
            .i_nbr_slot  (w_slot[i+1]),
            .i_nbr_delta (w_delta[i+1]),
            .i_nbr_tag   (w_tag[i+1]),
            .o_valid     (w_valid[i]),
            .o_slot      (w_slot[i]),
            .o_delta     (w_delta[i]),
            .o_tag       (w_tag[i]),
            .o_tok_mode  (w_tok_mode[i+1]),
            .o_tok_delta (w_tok_delta[i+1]),
            .o_tok_slot  (w_tok_slot[i+1]),
            .o_tok_tag   (w_tok_tag[i+1])
        );
    end

    // control terms
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_head_fire;
    logic                 w_next_fire;
    logic                 w_tok_done;
    logic [SLOT_BITS-1:0] w_busy_addr;
    logic                 w_busy_rd;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_head_fire   = w_valid[0] && (w_delta[0] == '0);
    assign w_next_fire   = w_valid[1] && (w_delta[1] == '0);
    assign w_tok_done    = (w_tok_mode[TIMER_SLOTS] != TOK_NONE);
    assign w_busy_addr   = (r_state == ST_SCAN) ? r_scan : w_del_idx;
    assign w_busy_rd     = r_busy[w_busy_addr];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_in_action)
                        ACT_CREATE: n_state = (w_in_rem == '0) ? ST_EMIT : ST_SCAN;
                        ACT_DELETE: n_state = (w_del_range && w_busy_rd) ? ST_WALK : ST_EMIT;
                        ACT_TICK:   n_state = w_valid[0] ? ST_DEC : ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!w_busy_rd) begin
                    n_state = ST_WALK;
                end else if (r_scan == SLOT_BITS'(TIMER_SLOTS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_WALK: begin
                if (w_tok_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_DEC: n_state = ST_FIRE;
            ST_FIRE: begin
                if (!w_head_fire) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_busy      = r_busy;
        n_scan      = r_scan;
        n_rem       = r_rem;
        n_tick      = r_tick;
        n_inj_mode  = TOK_NONE;
        n_inj_delta = r_inj_delta;
        n_inj_slot  = r_inj_slot;
        n_inj_tag   = r_inj_tag;
        n_res_kind  = r_res_kind;
        n_res_slot  = r_res_slot;
        n_res_tag   = r_res_tag;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_tag   = r_out_tag;
        n_out_tick  = r_out_tick;
        n_out_last  = r_out_last;
        c_cmd       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_in_action)
                        ACT_CREATE: begin
                            n_rem      = w_in_rem;
                            n_scan     = '0;
                            n_res_kind = KIND_CREATE_REJ;
                            n_res_slot = '0;
                            n_res_tag  = w_in_tag;
                        end
                        ACT_DELETE: begin
                            n_res_slot = w_in_slot;
                            if (w_del_range && w_busy_rd) begin
                                n_res_kind        = KIND_DELETED;
                                n_busy[w_del_idx] = 1'b0;
                                n_inj_mode        = TOK_DEL;
                                n_inj_slot        = w_del_idx;
                            end else begin
                                n_res_kind = KIND_DELETE_REJ;
                                n_res_tag  = '0;
                            end
                        end
                        ACT_TICK: begin
                            n_tick = r_tick + TICK_BITS'(1);
                        end
                        default: begin
                            n_tick = r_tick;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!w_busy_rd) begin
                    n_busy[r_scan] = 1'b1;
                    n_inj_mode     = TOK_INS;
                    n_inj_delta    = r_rem;
                    n_inj_slot     = r_scan;
                    n_inj_tag      = r_res_tag;
                    n_res_kind     = KIND_CREATED;
                    n_res_slot     = f_slot_out(r_scan);
                end else begin
                    n_scan = r_scan + SLOT_BITS'(1);
                end
            end
            ST_WALK: begin
                if (w_tok_done && (r_res_kind == KIND_DELETED)) begin
                    n_res_tag = w_tok_tag[TIMER_SLOTS];
                end
            end
            ST_DEC: begin
                c_cmd.dec = 1'b1;
            end
            ST_FIRE: begin
                if (w_head_fire && w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out_kind        = KIND_FIRED;
                    n_out_slot        = f_slot_out(w_slot[0]);
                    n_out_tag         = w_tag[0];
                    n_out_tick        = r_tick;
                    n_out_last        = !w_next_fire;
                    n_busy[w_slot[0]] = 1'b0;
                    c_cmd.shift_left  = 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_slot  = r_res_slot;
                    n_out_tag   = r_res_tag;
                    n_out_tick  = r_tick;
                    n_out_last  = 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= '0;
            r_tick      <= '0;
            r_inj_mode  <= TOK_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_tick      <= n_tick;
            r_inj_mode  <= n_inj_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_rem       <= n_rem;
        r_inj_delta <= n_inj_delta;
        r_inj_slot  <= n_inj_slot;
        r_inj_tag   <= n_inj_tag;
        r_res_kind  <= n_res_kind;
        r_res_slot  <= n_res_slot;
        r_res_tag   <= n_res_tag;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_tag   <= n_out_tag;
        r_out_tick  <= n_out_tick;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{M_PAD{1'b0}}, r_out_tick, r_out_tag, r_out_slot};
    assign m_axis_tlast  = r_out_last;

    // busy slots and listed cells agree between items
    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_busy) == $countones(w_valid)))
        else $error("busy slots differ from listed timers");

    // the head cell holds a timer whenever the second cell does
    a_list_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> w_valid[0])
        else $error("gap at head of timer list");

    // a token leaves the row only during a walk
    a_tok_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_done |-> (r_state == ST_WALK))
        else $error("stray token at end of cell row");

    // an expired head is reported as a fired result
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIRE) && w_head_fire && w_out_free)
        |=> (m_axis_tvalid && (m_axis_tuser == KIND_FIRED)))
        else $error("expired timer not reported");

endmodule

/* hdl/dltq_cell.sv */
// one cell of the delta list: holds one timer entry and a token stage
// a token moves one cell right per cycle; shift_left pulls the right neighbor
// depends on dltq_pkg
module dltq_cell #(
    parameter int DELTA_BITS = dltq_pkg::DEF_DELTA_BITS,
    parameter int SLOT_BITS  = $clog2(dltq_pkg::DEF_TIMER_SLOTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dltq_pkg::t_cell_cmd           i_cmd,
    input  dltq_pkg::t_tok_mode           i_tok_mode,
    input  logic [DELTA_BITS-1:0]         i_tok_delta,
    input  logic [SLOT_BITS-1:0]          i_tok_slot,
    input  logic [dltq_pkg::TAG_BITS-1:0] i_tok_tag,
    input  logic                          i_nbr_valid,
    input  logic [SLOT_BITS-1:0]          i_nbr_slot,
    input  logic [DELTA_BITS-1:0]         i_nbr_delta,
    input  logic [dltq_pkg::TAG_BITS-1:0] i_nbr_tag,
    output logic                          o_valid,
    output logic [SLOT_BITS-1:0]          o_slot,
    output logic [DELTA_BITS-1:0]         o_delta,
    output logic [dltq_pkg::TAG_BITS-1:0] o_tag,
    output dltq_pkg::t_tok_mode           o_tok_mode,
    output logic [DELTA_BITS-1:0]         o_tok_delta,
    output logic [SLOT_BITS-1:0]          o_tok_slot,
    output logic [dltq_pkg::TAG_BITS-1:0] o_tok_tag
);
    import dltq_pkg::*;

    logic                  r_valid, n_valid;
    logic [SLOT_BITS-1:0]  r_slot, n_slot;
    logic [DELTA_BITS-1:0] r_delta, n_delta;
    logic [TAG_BITS-1:0]   r_tag, n_tag;
    t_tok_mode             r_tok_mode, n_tok_mode;
    logic [DELTA_BITS-1:0] r_tok_delta, n_tok_delta;
    logic [SLOT_BITS-1:0]  r_tok_slot, n_tok_slot;
    logic [TAG_BITS-1:0]   r_tok_tag, n_tok_tag;

    logic [DELTA_BITS:0]   w_sum;
    logic [DELTA_BITS-1:0] w_sum_sat;

    // saturating merge of a removed delta into its successor
    assign w_sum     = {1'b0, r_delta} + {1'b0, i_nbr_delta};
    assign w_sum_sat = w_sum[DELTA_BITS] ? '1 : w_sum[DELTA_BITS-1:0];

    always_comb begin
        n_valid     = r_valid;
        n_slot      = r_slot;
        n_delta     = r_delta;
        n_tag       = r_tag;
        n_tok_mode  = TOK_NONE;
        n_tok_delta = i_tok_delta;
        n_tok_slot  = i_tok_slot;
        n_tok_tag   = i_tok_tag;

        if (i_cmd.shift_left) begin
            n_valid = i_nbr_valid;
            n_slot  = i_nbr_slot;
            n_delta = i_nbr_delta;
            n_tag   = i_nbr_tag;
        end else if (i_cmd.dec && r_valid && (r_delta != '0)) begin
            n_delta = r_delta - DELTA_BITS'(1);
        end

        case (i_tok_mode)
            TOK_INS: begin
                if (r_valid && (i_tok_delta > r_delta)) begin
                    n_tok_mode  = TOK_INS;
                    n_tok_delta = i_tok_delta - r_delta;
                end else begin
                    n_valid = 1'b1;
                    n_slot  = i_tok_slot;
                    n_delta = i_tok_delta;
                    n_tag   = i_tok_tag;
                    if (r_valid) begin
                        n_tok_mode  = TOK_CARRY;
                        n_tok_delta = r_delta - i_tok_delta;
                        n_tok_slot  = r_slot;
                        n_tok_tag   = r_tag;
                    end else begin
                        n_tok_mode = TOK_PASS;
                    end
                end
            end
            TOK_CARRY: begin
                n_valid = 1'b1;
                n_slot  = i_tok_slot;
                n_delta = i_tok_delta;
                n_tag   = i_tok_tag;
                if (r_valid) begin
                    n_tok_mode  = TOK_CARRY;
                    n_tok_delta = r_delta;
                    n_tok_slot  = r_slot;
                    n_tok_tag   = r_tag;
                end else begin
                    n_tok_mode = TOK_PASS;
                end
            end
            TOK_DEL: begin
                if (r_valid && (r_slot == i_tok_slot)) begin
                    // unlink: take the successor with the merged delta
                    n_tok_mode = TOK_PULL;
                    n_tok_tag  = r_tag;
                    n_valid    = i_nbr_valid;
                    n_slot     = i_nbr_slot;
                    n_delta    = w_sum_sat;
                    n_tag      = i_nbr_tag;
                end else begin
                    n_tok_mode = TOK_DEL;
                end
            end
            TOK_PULL: begin
                n_tok_mode = TOK_PULL;
                n_valid    = i_nbr_valid;
                n_slot     = i_nbr_slot;
                n_delta    = i_nbr_delta;
                n_tag      = i_nbr_tag;
            end
            TOK_PASS: begin
                n_tok_mode = TOK_PASS;
            end
            default: begin
                n_tok_mode = TOK_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_tok_mode <= TOK_NONE;
        end else begin
            r_valid    <= n_valid;
            r_tok_mode <= n_tok_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_delta     <= n_delta;
        r_tag       <= n_tag;
        r_tok_delta <= n_tok_delta;
        r_tok_slot  <= n_tok_slot;
        r_tok_tag   <= n_tok_tag;
    end

    assign o_valid     = r_valid;
    assign o_slot      = r_slot;
    assign o_delta     = r_delta;
    assign o_tag       = r_tag;
    assign o_tok_mode  = r_tok_mode;
    assign o_tok_delta = r_tok_delta;
    assign o_tok_slot  = r_tok_slot;
    assign o_tok_tag   = r_tok_tag;

endmodule
